### design/advisory_file_lock_table_core_macros.svh
// Assertion macros used by the lock table core design file.
`ifndef ADVISORY_FILE_LOCK_TABLE_CORE_MACROS_SVH
`define ADVISORY_FILE_LOCK_TABLE_CORE_MACROS_SVH

// Check a property on the rising edge of clk, skipped while rst_n is low.
`define AFLT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define AFLT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/aflt_pkg.sv
// Package with sizes, request and status codes of the lock table.
`timescale 1ns / 1ps
package aflt_pkg;

  localparam int LOCK_SLOTS = 16;
  localparam int SLOT_W     = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

  localparam int FILE_W   = 32;
  localparam int OWNER_W  = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOCK_SH  = 2'd0,
    OP_LOCK_EX  = 2'd1,
    OP_UNLOCK   = 2'd2,
    OP_BAD      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_MUST_WAIT   = 3'd2,
    ST_INVALID     = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

endpackage

### design/advisory_file_lock_table_core.sv
// Top level of the whole-file shared/exclusive lock table.
// Each request is scanned slot by slot and then finished; out_tvalid is registered from the
// finish step, and an invalid request skips the scan. One comparator scans one slot per cycle.
// in_tready is high only while idle, so no new request is taken until the last one has left
// the finish step; a result still waiting on out_tready holds the finish step and in_tready.
// Reset (rst_n low, synchronous) clears all slot valid bits, the sequencer and the output.
`timescale 1ns / 1ps
`include "advisory_file_lock_table_core_macros.svh"
module advisory_file_lock_table_core
  import aflt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] nonblocking, [32:1] file_id, [48:33] owner_id, [55:49] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [3] wake_waiters, [7:4] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  op_t                   op_r;
  logic                  nb_r;
  logic [FILE_W-1:0]     file_r;
  logic [OWNER_W-1:0]    owner_r;
  logic                  invalid_r, invalid_nxt;
  logic                  conflict_r, conflict_nxt;
  logic [LOCK_SLOTS-1:0] own_mask_r, own_mask_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]     free_idx_r, free_idx_nxt;
  logic [LOCK_SLOTS-1:0] valid_r, valid_nxt;

  logic [FILE_W-1:0]     slot_file_r  [LOCK_SLOTS];
  logic [OWNER_W-1:0]    slot_owner_r [LOCK_SLOTS];
  logic                  slot_excl_r  [LOCK_SLOTS];

  logic                  out_tvalid_r, out_tvalid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_wake_r, out_wake_nxt;

  logic                  in_accept;
  logic                  fin_fire;
  logic                  grant;
  logic                  want_excl;
  logic                  cur_match;
  logic                  cur_same_owner;
  logic                  last_slot;
  logic [FILE_W-1:0]     in_file;
  logic [OWNER_W-1:0]    in_owner;
  op_t                   in_op;

  assign in_op     = op_t'(in_tuser);
  assign in_file   = in_tdata[FILE_W:1];
  assign in_owner  = in_tdata[FILE_W+OWNER_W:FILE_W+1];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign fin_fire  = (state_r == S_FINISH) && (!out_tvalid_r || out_tready);
  assign want_excl = (op_r == OP_LOCK_EX);
  assign last_slot = (idx_r == SLOT_W'(LOCK_SLOTS - 1));

  assign cur_match      = valid_r[idx_r] && (slot_file_r[idx_r] == file_r);
  assign cur_same_owner = (slot_owner_r[idx_r] == owner_r);

  assign grant = !invalid_r && (op_r != OP_UNLOCK) && !conflict_r && free_found_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    invalid_nxt    = invalid_r;
    conflict_nxt   = conflict_r;
    own_mask_nxt   = own_mask_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    out_tvalid_nxt = out_tvalid_r;
    out_status_nxt = out_status_r;
    out_wake_nxt   = out_wake_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          invalid_nxt    = (in_file == '0) || (in_owner == '0) || (in_op == OP_BAD);
          conflict_nxt   = 1'b0;
          own_mask_nxt   = '0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          idx_nxt        = '0;
          state_nxt      = invalid_nxt ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        // A slot is free after the drop if empty or held by this owner on this file.
        if (cur_match && cur_same_owner) begin
          own_mask_nxt[idx_r] = 1'b1;
        end
        if (cur_match && !cur_same_owner && (want_excl || slot_excl_r[idx_r])) begin
          conflict_nxt = 1'b1;
        end
        if (!free_found_r && (!valid_r[idx_r] || (cur_match && cur_same_owner))) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        if (last_slot) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      S_FINISH: begin
        if (fin_fire) begin
          out_tvalid_nxt = 1'b1;
          out_wake_nxt   = 1'b0;
          priority if (invalid_r) begin
            out_status_nxt = ST_INVALID;
          end else if (op_r == OP_UNLOCK) begin
            out_status_nxt = ST_OK;
            out_wake_nxt   = 1'b1;
            valid_nxt      = valid_r & ~own_mask_r;
          end else if (conflict_r) begin
            out_status_nxt = nb_r ? ST_WOULD_BLOCK : ST_MUST_WAIT;
          end else if (!free_found_r) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt         = ST_OK;
            valid_nxt              = valid_r & ~own_mask_r;
            valid_nxt[free_idx_r]  = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      invalid_r    <= 1'b0;
      conflict_r   <= 1'b0;
      own_mask_r   <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
      out_status_r <= ST_OK;
      out_wake_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      invalid_r    <= invalid_nxt;
      conflict_r   <= conflict_nxt;
      own_mask_r   <= own_mask_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_status_r <= out_status_nxt;
      out_wake_r   <= out_wake_nxt;
    end
  end

  // Hold the request while it is scanned.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_op;
      nb_r    <= in_tdata[0];
      file_r  <= in_file;
      owner_r <= in_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire && grant) begin
      slot_file_r[free_idx_r]  <= file_r;
      slot_owner_r[free_idx_r] <= owner_r;
      slot_excl_r[free_idx_r]  <= want_excl;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - 1){1'b0}}, out_wake_r, out_status_r};

  `AFLT_CHECK(a_scan_starts_at_zero, (in_accept && !invalid_nxt) |=> (state_r == S_SCAN && idx_r == '0), "scan did not start at slot zero")
  `AFLT_CHECK(a_wake_only_ok, out_tvalid_r |-> (!out_wake_r || out_status_r == ST_OK), "wake raised with a non-OK status")
  `AFLT_CHECK(a_grant_sets_slot, (fin_fire && grant) |=> valid_r[$past(free_idx_r)], "granted lock left its slot empty")
  `AFLT_CHECK(a_reject_keeps_table, (fin_fire && (invalid_r || (conflict_r && op_r != OP_UNLOCK))) |=> $stable(valid_r), "rejected request changed the table")
  `AFLT_CHECK_ALWAYS(a_state_onehot, !rst_n || $onehot(state_r), "sequencer state not one-hot")

endmodule

### bench/tb_advisory_file_lock_table_core.sv
// Self-checking testbench for the whole-file shared/exclusive lock table core.
`timescale 1ns / 1ps
module tb_advisory_file_lock_table_core;
  import aflt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_OFF_AT   = 300;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int FILE_POOL     = 24;
  localparam int OWNER_POOL    = 4;

  typedef struct {
    status_t status;
    logic    wake;
  } lock_result_t;

  typedef struct {
    op_t          op;
    logic         nonblocking;
    logic [31:0]  file_id;
    logic [15:0]  owner_id;
    bit           typed;
    lock_result_t want;
  } request_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic rx_ready;
  logic rx_hold;
  bit   burst_phase;
  int   accepted_requests;
  int   mismatches;

  // Shadow copy of the lock table
  logic        held_valid [LOCK_SLOTS];
  logic [31:0] held_file  [LOCK_SLOTS];
  logic [15:0] held_owner [LOCK_SLOTS];
  logic        held_excl  [LOCK_SLOTS];

  lock_result_t pending_results[$];
  request_row_t request_rows[$];

  assign out_tready = rx_ready & ~rx_hold;

  advisory_file_lock_table_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void drop_owner_entries(logic [31:0] file_id, logic [15:0] owner_id);
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (held_valid[i] && held_file[i] == file_id && held_owner[i] == owner_id)
        held_valid[i] = 1'b0;
    end
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (!held_valid[i]) return i;
    end
    return -1;
  endfunction

  function automatic lock_result_t apply_lock_request(op_t op, logic nonblocking,
                                                      logic [31:0] file_id,
                                                      logic [15:0] owner_id);
    lock_result_t r;
    bit conflict;
    bit owner_has;
    int slot;
    r.status  = ST_OK;
    r.wake    = 1'b0;
    conflict  = 1'b0;
    owner_has = 1'b0;
    if (file_id == '0 || owner_id == '0 || op == OP_BAD) begin
      r.status = ST_INVALID;
    end else if (op == OP_UNLOCK) begin
      drop_owner_entries(file_id, owner_id);
      r.wake = 1'b1;
    end else begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
        if (held_valid[i] && held_file[i] == file_id) begin
          if (held_owner[i] == owner_id) owner_has = 1'b1;
          else if (op == OP_LOCK_EX || held_excl[i]) conflict = 1'b1;
        end
      end
      if (conflict) begin
        r.status = nonblocking ? ST_WOULD_BLOCK : ST_MUST_WAIT;
      end else if (!owner_has && lowest_free_slot() < 0) begin
        r.status = ST_FULL;
      end else begin
        // replace the owner's old entry, new one goes to the lowest free slot
        drop_owner_entries(file_id, owner_id);
        slot = lowest_free_slot();
        held_valid[slot] = 1'b1;
        held_file[slot]  = file_id;
        held_owner[slot] = owner_id;
        held_excl[slot]  = (op == OP_LOCK_EX);
      end
    end
    return r;
  endfunction

  function automatic void add_row(op_t op, logic nonblocking, logic [31:0] file_id,
                                  logic [15:0] owner_id, bit typed,
                                  status_t want_status, logic want_wake);
    request_row_t row;
    row.op          = op;
    row.nonblocking = nonblocking;
    row.file_id     = file_id;
    row.owner_id    = owner_id;
    row.typed       = typed;
    row.want.status = want_status;
    row.want.wake   = want_wake;
    request_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // Drive one request at the falling edge, wait for its handshake, then predict.
  task automatic offer_request(request_row_t row);
    int gap;
    lock_result_t predicted;
    gap = burst_phase ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = row.op;
    in_tdata  = {7'b0, row.owner_id, row.file_id, row.nonblocking};
    do @(posedge clk); while (!in_tready);
    predicted = apply_lock_request(row.op, row.nonblocking, row.file_id, row.owner_id);
    pending_results.push_back(row.typed ? row.want : predicted);
    accepted_requests++;
  endtask

  initial begin
    logic [31:0]  file_pool  [FILE_POOL];
    logic [15:0]  owner_pool [OWNER_POOL];
    request_row_t row;
    int           pick;

    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tuser          = OP_LOCK_SH;
    burst_phase       = 1'b0;
    accepted_requests = 0;
    mismatches        = 0;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      held_valid[i] = 1'b0;
      held_file[i]  = '0;
      held_owner[i] = '0;
      held_excl[i]  = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // null ids and malformed operation
    add_row(OP_BAD,     1'b1, 32'd1, 16'd1, 1'b1, ST_INVALID, 1'b0);
    add_row(OP_LOCK_SH, 1'b0, 32'd0, 16'd1, 1'b1, ST_INVALID, 1'b0);
    add_row(OP_LOCK_EX, 1'b1, 32'd1, 16'd0, 1'b1, ST_INVALID, 1'b0);
    add_row(OP_UNLOCK,  1'b0, 32'd0, 16'd0, 1'b1, ST_INVALID, 1'b0);
    // unlock with nothing held still wakes
    add_row(OP_UNLOCK,  1'b1, 32'd5, 16'd7, 1'b1, ST_OK, 1'b1);
    // two shared holders on the top file id, then exclusive conflicts
    add_row(OP_LOCK_SH, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_OK, 1'b0);
    add_row(OP_LOCK_SH, 1'b1, 32'hFFFF_FFFF, 16'h0001, 1'b1, ST_OK, 1'b0);
    add_row(OP_LOCK_EX, 1'b1, 32'hFFFF_FFFF, 16'h0001, 1'b1, ST_WOULD_BLOCK, 1'b0);
    add_row(OP_LOCK_EX, 1'b0, 32'hFFFF_FFFF, 16'h0001, 1'b1, ST_MUST_WAIT, 1'b0);
    // fill the remaining slots
    for (int i = 0; i < LOCK_SLOTS - 2; i++)
      add_row(OP_LOCK_EX, logic'(i & 1), 32'(i + 1), 16'h8000, 1'b0, ST_OK, 1'b0);
    add_row(OP_LOCK_SH, 1'b1, 32'h0000_0020, 16'd3, 1'b1, ST_FULL, 1'b0);
    // downgrade in place while the table is full
    add_row(OP_LOCK_SH, 1'b0, 32'd1, 16'h8000, 1'b0, ST_OK, 1'b0);
    add_row(OP_UNLOCK,  1'b0, 32'hFFFF_FFFF, 16'h0001, 1'b1, ST_OK, 1'b1);

    foreach (request_rows[i]) offer_request(request_rows[i]);

    for (int i = 0; i < FILE_POOL; i++) begin
      file_pool[i] = $urandom();
      if (file_pool[i] == '0) file_pool[i] = 32'd1;
    end
    for (int i = 0; i < OWNER_POOL; i++) begin
      owner_pool[i] = 16'($urandom_range(1, 16'hFFFF));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      burst_phase = (n % 200) >= 150;
      pick = $urandom_range(0, 99);
      row.nonblocking = 1'($urandom_range(0, 1));
      row.file_id     = file_pool[$urandom_range(0, FILE_POOL - 1)];
      row.owner_id    = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
      row.typed       = 1'b0;
      row.want.status = ST_OK;
      row.want.wake   = 1'b0;
      if (pick < 35) begin
        row.op = OP_LOCK_SH;
      end else if (pick < 65) begin
        row.op = OP_LOCK_EX;
      end else if (pick < 90) begin
        row.op = OP_UNLOCK;
      end else begin
        // noise: malformed, null or fully random ids
        row.op = op_t'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
          0: row.file_id = '0;
          1: row.owner_id = '0;
          default: begin
            row.file_id  = $urandom();
            row.owner_id = 16'($urandom());
          end
        endcase
      end
      offer_request(row);
    end
    burst_phase = 1'b0;
    @(negedge clk);
    in_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_advisory_file_lock_table_core: done, clean");
    end else begin
      $display("tb_advisory_file_lock_table_core: done, errors");
    end
    $finish;
  end

  // Result side: random stalls, check each accepted result against the oldest prediction.
  initial begin
    int stall;
    lock_result_t want;
    rx_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = burst_phase ? 0 : $urandom_range(0, 16);
      @(negedge clk);
      if (stall > 0) begin
        rx_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rx_ready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_tdata[2:0], 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] != want.status)
          report_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[3] != want.wake)
          report_mismatch("wake_waiters", out_tdata[3], want.wake);
      end
    end
  end

  // Hold the result side off for a long stretch so requests back up.
  initial begin
    rx_hold = 1'b0;
    wait (accepted_requests >= HOLD_OFF_AT);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_LEN) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_advisory_file_lock_table_core: done, errors");
    $finish;
  end

endmodule
